/* design/tsv_pkg.sv */
`timescale 1ns / 1ps

package tsv_pkg;

  // Width of the code held while an opcode waits for its operand.
  localparam int PEND_W = 4;

  // Pending opcode codes: a note, or the negated opcode byte.
  localparam logic [PEND_W-1:0] OP_NOTE    = 4'd0;
  localparam logic [PEND_W-1:0] OP_SILENCE = 4'd1;
  localparam logic [PEND_W-1:0] OP_VERSION = 4'd2;
  localparam logic [PEND_W-1:0] OP_TEMPO   = 4'd3;
  localparam logic [PEND_W-1:0] OP_RES     = 4'd4;
  localparam logic [PEND_W-1:0] OP_BSTART  = 4'd5;
  localparam logic [PEND_W-1:0] OP_BEND    = 4'd6;
  localparam logic [PEND_W-1:0] OP_PLAY    = 4'd7;
  localparam logic [PEND_W-1:0] OP_VOLUME  = 4'd8;
  localparam logic [PEND_W-1:0] OP_REPEAT  = 4'd9;

  // Lowest opcode byte that is recognized.
  localparam logic signed [7:0] OPCODE_MIN = -8'sd9;

  // One registered input byte on its way to the checker.
  typedef struct packed {
    logic signed [7:0] tone_byte;
    logic              last_byte;
  } tsv_item_t;

endpackage

/* design/tsv_in_reg.sv */
`timescale 1ns / 1ps

module tsv_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [7:0]  in_tone_byte,
  input  logic               in_last_byte,
  input  logic               advance,
  output logic               item_valid,
  output tsv_pkg::tsv_item_t item
);
  import tsv_pkg::*;

  logic      valid_r;
  tsv_item_t item_r;

  // The register takes a new byte whenever its current byte moves on.
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.tone_byte <= in_tone_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

endmodule

/* design/tsv_check.sv */
`timescale 1ns / 1ps

module tsv_check #(
  parameter int BLOCK_COUNT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  tsv_pkg::tsv_item_t item,
  output logic               verdict
);
  import tsv_pkg::*;

  localparam int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam logic [7:0] BLOCK_LIMIT = 8'(BLOCK_COUNT);

  logic                   expect_r, expect_nxt;
  logic [PEND_W-1:0]      pending_r, pending_nxt;
  logic                   open_vld_r, open_vld_nxt;
  logic [6:0]             open_num_r, open_num_nxt;
  logic [BLOCK_COUNT-1:0] defined_r, defined_nxt;
  logic                   tempo_r, tempo_nxt;
  logic                   res_r, res_nxt;
  logic                   failed_r, failed_nxt;

  logic signed [7:0] v;
  logic [7:0]        neg_v;
  logic              blk_ok;
  logic [IDX_W-1:0]  blk_idx;
  logic              op_ok;

  // Parse one byte: either check an operand or latch a new opcode.
  always_comb begin
    v            = item.tone_byte;
    neg_v        = 8'(-v);
    blk_ok       = !v[7] && ({1'b0, v[6:0]} < BLOCK_LIMIT);
    blk_idx      = IDX_W'(v[6:0]);
    op_ok        = 1'b0;
    expect_nxt   = expect_r;
    pending_nxt  = pending_r;
    open_vld_nxt = open_vld_r;
    open_num_nxt = open_num_r;
    defined_nxt  = defined_r;
    tempo_nxt    = tempo_r;
    res_nxt      = res_r;
    failed_nxt   = failed_r;

    if (!failed_r) begin
      if (expect_r) begin
        unique case (pending_r)
          OP_SILENCE: op_ok = (v >= 8'sd1);
          OP_VERSION: op_ok = (v == 8'sd1);
          OP_TEMPO: begin
            op_ok = !tempo_r && (v >= 8'sd5);
            if (op_ok) tempo_nxt = 1'b1;
          end
          OP_RES: begin
            op_ok = !res_r && (v >= 8'sd1);
            if (op_ok) res_nxt = 1'b1;
          end
          OP_BSTART: begin
            op_ok = blk_ok;
            if (op_ok) begin
              open_vld_nxt = 1'b1;
              open_num_nxt = v[6:0];
            end
          end
          OP_BEND: begin
            op_ok = open_vld_r && blk_ok && (v[6:0] == open_num_r);
            if (op_ok) begin
              defined_nxt[blk_idx] = 1'b1;
              open_vld_nxt         = 1'b0;
            end
          end
          OP_PLAY:   op_ok = blk_ok && defined_r[blk_idx];
          OP_VOLUME: op_ok = (v >= 8'sd0) && (v <= 8'sd100);
          OP_REPEAT: op_ok = (v >= 8'sd2);
          default:   op_ok = (v >= 8'sd1);
        endcase
        failed_nxt  = !op_ok;
        expect_nxt  = 1'b0;
        pending_nxt = OP_NOTE;
      end else if (!v[7]) begin
        pending_nxt = OP_NOTE;
        expect_nxt  = 1'b1;
      end else if (v >= OPCODE_MIN) begin
        pending_nxt = neg_v[PEND_W-1:0];
        expect_nxt  = 1'b1;
      end else begin
        failed_nxt = 1'b1;
      end
    end

    // A sequence ending on an opcode or a note lacks its operand and fails.
    verdict = !failed_nxt && !expect_nxt;

    // The last byte returns everything to its starting state.
    if (item.last_byte) begin
      expect_nxt   = 1'b0;
      pending_nxt  = OP_NOTE;
      open_vld_nxt = 1'b0;
      defined_nxt  = '0;
      tempo_nxt    = 1'b0;
      res_nxt      = 1'b0;
      failed_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r   <= 1'b0;
      pending_r  <= OP_NOTE;
      open_vld_r <= 1'b0;
      defined_r  <= '0;
      tempo_r    <= 1'b0;
      res_r      <= 1'b0;
      failed_r   <= 1'b0;
    end else if (fire) begin
      expect_r   <= expect_nxt;
      pending_r  <= pending_nxt;
      open_vld_r <= open_vld_nxt;
      defined_r  <= defined_nxt;
      tempo_r    <= tempo_nxt;
      res_r      <= res_nxt;
      failed_r   <= failed_nxt;
    end
  end

  // The open block number is only meaningful while its flag is set.
  always_ff @(posedge clk) begin
    if (fire) begin
      open_num_r <= open_num_nxt;
    end
  end

endmodule

/* design/tone_sequence_validator_top.sv */
`timescale 1ns / 1ps

// Tone sequence validator. Bytes of a tone sequence arrive one per transfer as
// opcode and operand pairs; the byte marked last yields one verdict transfer,
// 1 when every check passed, and then all tracking state clears for the next
// sequence. A byte is taken every cycle unless the input stalls: each byte
// passes from an input register through the checker into the result register,
// where a last byte's verdict is registered. Input stalls only while a
// finished verdict is held by a stalled output and a further last byte waits.
// BLOCK_COUNT sets how many block numbers the block-defined bitmap tracks.
module tone_sequence_validator_top #(
  parameter int BLOCK_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_tone_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_sequence_valid
);
  import tsv_pkg::*;

  logic      item_valid;
  tsv_item_t item;
  logic      advance;
  logic      out_free;
  logic      verdict;
  logic      out_valid_r;
  logic      out_seq_r;

  // A non-final byte always moves on; a final one needs room for its verdict.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid && (!item.last_byte || out_free);

  tsv_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tone_byte (in_tone_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  tsv_check #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (item),
    .verdict (verdict)
  );

  // Result register: holds a verdict until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_seq_r <= verdict;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sequence_valid = out_seq_r;

endmodule

/* design/tsv_checker.sv */
`timescale 1ns / 1ps

module tsv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic signed [7:0] in_tone_byte,
  input logic              in_last_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_sequence_valid
);

  // A stalled verdict stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sequence_valid))
    else $error("stalled verdict changed or dropped");

  // Reset leaves no verdict pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict offered after reset");

  // The input side is held back only by a blocked output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  // A stalled input byte stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_tone_byte) &&
      $stable(in_last_byte))
    else $error("stalled input byte changed or dropped");

endmodule

bind tone_sequence_validator_top tsv_checker u_tsv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_tone_byte       (in_tone_byte),
  .in_last_byte       (in_last_byte),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sequence_valid (out_sequence_valid)
);

/* test/tone_verdict_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the tone sequence validator. Every accepted byte
// updates a private copy of the sequence state; every verdict transfer is
// compared with the oldest verdict still owed.
module tone_verdict_checker #(
  parameter int BLOCK_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic signed [7:0] in_tone_byte,
  input  logic              in_last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_sequence_valid,
  output int                mismatches,
  output int                verdicts_owed
);
  import tsv_pkg::*;

  // Sequence state as the block should hold it.
  logic                   awaiting_operand = 1'b0;
  logic [PEND_W-1:0]      held_op          = OP_NOTE;
  int                     open_blk         = -1;
  logic [BLOCK_COUNT-1:0] closed_blocks    = '0;
  logic                   tempo_used       = 1'b0;
  logic                   res_used         = 1'b0;
  logic                   seq_failed       = 1'b0;

  // Verdicts owed, oldest first.
  logic verdicts_due[$];
  logic want;

  initial begin
    mismatches    = 0;
    verdicts_owed = 0;
  end

  function automatic logic block_number_ok(input int v);
    return v >= 0 && v <= 127 && v < BLOCK_COUNT;
  endfunction

  // Judges an operand against the opcode waiting for it; some operands
  // also change the tracked state.
  function automatic logic operand_passes(input int v);
    case (held_op)
      OP_SILENCE: return v >= 1 && v <= 127;
      OP_VERSION: return v == 1;
      OP_TEMPO: begin
        if (tempo_used || v < 5 || v > 127) return 1'b0;
        tempo_used = 1'b1;
        return 1'b1;
      end
      OP_RES: begin
        if (res_used || v < 1 || v > 127) return 1'b0;
        res_used = 1'b1;
        return 1'b1;
      end
      OP_BSTART: begin
        if (!block_number_ok(v)) return 1'b0;
        open_blk = v;
        return 1'b1;
      end
      OP_BEND: begin
        if (open_blk < 0 || v != open_blk || !block_number_ok(v)) return 1'b0;
        closed_blocks[v] = 1'b1;
        open_blk = -1;
        return 1'b1;
      end
      OP_PLAY:   return block_number_ok(v) && closed_blocks[v];
      OP_VOLUME: return v >= 0 && v <= 100;
      OP_REPEAT: return v >= 2 && v <= 127;
      default:   return v >= 1 && v <= 127;
    endcase
  endfunction

  // Advances the state by one byte; the last byte of a sequence leaves a
  // verdict behind and clears everything.
  task automatic absorb_tone_byte(input logic signed [7:0] b, input logic last);
    int v;
    v = b;
    if (!seq_failed) begin
      if (awaiting_operand) begin
        if (!operand_passes(v)) seq_failed = 1'b1;
        awaiting_operand = 1'b0;
        held_op = OP_NOTE;
      end else if (v >= 0) begin
        held_op = OP_NOTE;
        awaiting_operand = 1'b1;
      end else if (v >= int'(OPCODE_MIN)) begin
        held_op = PEND_W'(0 - v);
        awaiting_operand = 1'b1;
      end else begin
        seq_failed = 1'b1;
      end
    end
    if (last) begin
      verdicts_due.push_back(!seq_failed && !awaiting_operand);
      awaiting_operand = 1'b0;
      held_op = OP_NOTE;
      open_blk = -1;
      closed_blocks = '0;
      tempo_used = 1'b0;
      res_used = 1'b0;
      seq_failed = 1'b0;
    end
  endtask

  task automatic report_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) absorb_tone_byte(in_tone_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_failure($sformatf("verdict %0b with no sequence finished",
                                   out_sequence_valid));
        end else begin
          want = verdicts_due.pop_front();
          if (out_sequence_valid !== want)
            report_failure($sformatf("sequence_valid expected %0b, got %0b",
                                     want, out_sequence_valid));
        end
      end
      verdicts_owed = verdicts_due.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tsv_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic signed [7:0] in_tone_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_sequence_valid;

  int mismatches;
  int verdicts_owed;

  // Stimulus pacing shared with the receiving side.
  logic steady        = 1'b0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   bytes_sent    = 0;

  // Sequence under construction and what the generator knows about it.
  logic [7:0] seq_q[$];
  int         gen_open;
  int         gen_defined[$];
  logic       gen_tempo;
  logic       gen_res;

  tone_sequence_validator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tone_byte       (in_tone_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sequence_valid (out_sequence_valid)
  );

  tone_verdict_checker verdict_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tone_byte       (in_tone_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sequence_valid (out_sequence_valid),
    .mismatches         (mismatches),
    .verdicts_owed      (verdicts_owed)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] opcode_of(input logic [PEND_W-1:0] code);
    return 8'(0 - int'(code));
  endfunction

  // Block numbers mostly stay low so that starts, ends and plays meet each other.
  function automatic int pick_block();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(0, 7);
  endfunction

  // Offers one byte, holds it until the transfer, then may idle for a while.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_tone_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_tone_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_sequence();
    for (int i = 0; i < seq_q.size(); i++) send_byte(seq_q[i], i == seq_q.size() - 1);
    seq_q.delete();
  endtask

  task automatic push_pair(input logic [PEND_W-1:0] code, input logic [7:0] opnd);
    seq_q.push_back(opcode_of(code));
    seq_q.push_back(opnd);
  endtask

  // Stops offering bytes and waits until every verdict owed has been
  // transferred.
  task automatic drain();
    in_valid <= 1'b0;
    wait (verdicts_owed == 0);
    @(negedge clk);
  endtask

  // Appends one opcode and operand pair, mostly well formed. Block ends and
  // plays bring along the pairs that make them legal.
  task automatic add_pair();
    logic [PEND_W-1:0] code;
    logic [7:0]        opnd;
    int                blk;
    code = PEND_W'($urandom_range(0, 9));
    if ((code == OP_TEMPO && gen_tempo) || (code == OP_RES && gen_res))
      if ($urandom_range(0, 3) != 0) code = OP_VOLUME;
    case (code)
      OP_VERSION: opnd = 8'd1;
      OP_TEMPO: begin
        gen_tempo = 1'b1;
        opnd = 8'($urandom_range(5, 127));
      end
      OP_RES: begin
        gen_res = 1'b1;
        opnd = 8'($urandom_range(1, 127));
      end
      OP_BSTART: begin
        gen_open = pick_block();
        opnd = 8'(gen_open);
      end
      OP_BEND: begin
        if (gen_open < 0) begin
          gen_open = pick_block();
          push_pair(OP_BSTART, 8'(gen_open));
        end
        opnd = 8'(gen_open);
        gen_defined.push_back(gen_open);
        gen_open = -1;
      end
      OP_PLAY: begin
        if (gen_defined.size() == 0 || $urandom_range(0, 4) == 0) begin
          blk = pick_block();
          push_pair(OP_BSTART, 8'(blk));
          push_pair(OP_BEND, 8'(blk));
          gen_defined.push_back(blk);
          gen_open = -1;
        end
        opnd = 8'(gen_defined[$urandom_range(0, gen_defined.size() - 1)]);
      end
      OP_VOLUME: opnd = 8'($urandom_range(0, 100));
      OP_REPEAT: opnd = 8'($urandom_range(2, 127));
      default:   opnd = 8'($urandom_range(1, 127));
    endcase
    if ($urandom_range(0, 11) == 0) opnd = 8'($urandom);
    if (code == OP_NOTE) seq_q.push_back(8'($urandom_range(0, 127)));
    else seq_q.push_back(opcode_of(code));
    seq_q.push_back(opnd);
  endtask

  // Mostly well-formed sequences of random content; some end on an opcode,
  // carry a stray byte, or are plain noise.
  task automatic build_sequence();
    int r;
    int pairs;
    gen_open = -1;
    gen_defined.delete();
    gen_tempo = 1'b0;
    gen_res = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 85) pairs = $urandom_range(1, 4);
    else if (r < 97) pairs = $urandom_range(5, 12);
    else pairs = $urandom_range(30, 60);
    repeat (pairs) add_pair();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      seq_q.push_back(8'($urandom));
    end else if (r < 9) begin
      seq_q.insert($urandom_range(0, seq_q.size() - 1), 8'($urandom));
    end else if (r < 12) begin
      seq_q.delete();
      repeat ($urandom_range(1, 6)) seq_q.push_back(8'($urandom));
    end
  endtask

  // Receiving side: random stalls, a long hold-off on request, none while
  // the stimulus runs steady.
  initial begin : receiver
    int busy;
    int idle;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (holds_served < hold_requests) begin
        holds_served++;
        busy = 80;
      end else if (steady) begin
        busy = 0;
      end else begin
        busy = pick_stall();
      end
      idle = steady ? 1 : $urandom_range(1, 6);
      if (busy > 0) begin
        out_stall <= 1'b1;
        repeat (busy) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat (idle) @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int seq_no;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_tone_byte = '0;
    in_last_byte = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every operation but silence, a block start replaced while open, and operand
    // extremes; the sequence is valid.
    push_pair(OP_VERSION, 8'd1);
    push_pair(OP_TEMPO, 8'd127);
    push_pair(OP_RES, 8'd127);
    push_pair(OP_BSTART, 8'd127);
    push_pair(OP_BSTART, 8'd3);
    push_pair(OP_BEND, 8'd3);
    push_pair(OP_PLAY, 8'd3);
    push_pair(OP_VOLUME, 8'd0);
    push_pair(OP_REPEAT, 8'd127);
    seq_q.push_back(8'd127);
    seq_q.push_back(8'd1);
    send_sequence();
    // A one-byte sequence holding the lowest byte, an unknown opcode.
    seq_q.push_back(8'h80);
    send_sequence();
    // An opcode just below the known range, then a byte absorbed after it.
    seq_q.push_back(opcode_of(PEND_W'(10)));
    seq_q.push_back(8'd1);
    send_sequence();
    // A note whose duration never comes.
    seq_q.push_back(8'd0);
    send_sequence();
    drain();

    seq_no = 0;
    while (bytes_sent < 1950) begin
      seq_no++;
      if (seq_no % 20 == 0) steady = ($urandom_range(0, 4) == 0);
      if (seq_no == 40 || seq_no == 160) begin
        // Long hold-off at the output while bytes keep coming.
        steady = 1'b1;
        hold_requests++;
        wait (holds_served == hold_requests);
        repeat (8) begin
          add_pair();
          send_sequence();
        end
        steady = 1'b0;
      end
      build_sequence();
      send_sequence();
      if (seq_no % 37 == 0) drain();
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tone_sequence_validator_top: match");
    end else begin
      $display("tone_sequence_validator_top: mismatch");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #6ms;
    $display("tone_sequence_validator_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/tsv_pkg.sv
design/tsv_in_reg.sv
design/tsv_check.sv
design/tone_sequence_validator_top.sv
design/tsv_checker.sv
test/tone_verdict_checker.sv
test/testbench.sv
